[rtl/core/cmp_pkg.sv]
`default_nettype none

package cmp_pkg;

  localparam int unsigned MAX_COMPONENTS = 16;

  localparam int unsigned MASS_W  = 32;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned LOC_W   = 48;
  localparam int unsigned TOTAL_W = 36;
  localparam int unsigned MOM_W   = 64;
  localparam int unsigned ACC_W   = 128;
  localparam int unsigned OPND_W  = 33;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned QUO_W   = 33;
  localparam int unsigned ENTRY_W = MASS_W + 3 * POS_W + 3 * LOC_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [QUO_W-1:0]   QUO_CLAMP = 33'h0_8000_0000;

  // sub-steps of one pair in the inertia pass
  localparam logic [1:0] SUB_SQ = 2'd0;
  localparam logic [1:0] SUB_LO = 2'd1;
  localparam logic [1:0] SUB_HI = 2'd2;

  // pairs 0..2 are squares (moments), 3..5 are xy, xz, yz (products)
  localparam logic [2:0] PAIR_FIRST_PROD = 3'd3;
  localparam logic [2:0] PAIR_LAST       = 3'd5;
  localparam logic [1:0] AXIS_LAST       = 2'd2;

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_P1_LOAD   = 13'h0002,
    S_P1_MUL    = 13'h0004,
    S_P1_ACC    = 13'h0008,
    S_DIV_START = 13'h0010,
    S_DIV_WAIT  = 13'h0020,
    S_P2_LOAD   = 13'h0040,
    S_P2_LATCH  = 13'h0080,
    S_P2_MUL    = 13'h0100,
    S_P2_ACC    = 13'h0200,
    S_P2_ACC2   = 13'h0400,
    S_P2_LOC    = 13'h0800,
    S_DONE      = 13'h1000
  } state_e;

  function automatic logic [1:0] pair_a(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // accumulators: 0..2 moments xx, yy, zz; 3..5 products xy, xz, yz
  function automatic logic [2:0] pair_tgt1(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd1;
      3'd3:    r = 3'd3;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_tgt2(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd2:    r = 3'd1;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  // drop 32 fraction bits, saturate to 64-bit signed; msb is the overflow flag
  function automatic logic [MOM_W:0] q16_sat(input logic [ACC_W-1:0] v);
    logic [MOM_W:0] r;
    if ((&v[127:95]) || !(|v[127:95])) begin
      r = {1'b0, v[95:32]};
    end else begin
      r = {1'b1, v[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/combined_mass_properties_top.sv]
`default_nettype none

// Combined mass properties of a group of up to MaxComp rigid-body components. Each accepted
// word appends one component (mass, position, principal local moments) to an on-chip store,
// or clears the store first when start_group_i is set, and yields one result word: total
// mass, mass-weighted centre, and the inertia tensor about that centre by the parallel axis
// theorem, off-diagonal terms negated. All products go through one shared 33x33 multiplier
// and each centre axis through a bit-serial divider on FirstW = 65 + log2(MaxComp) bit
// numerators, 69 by default. An item takes a first-moment pass over the stored components,
// one divider pass per axis, and an inertia pass over the components. The input is stalled
// until the result is loaded into the output register, where it sits until taken. A full
// store drops the new component and raises fault, as do zero total mass and saturation of
// the total mass or an inertia term; an overflowing centre is clamped without fault.
module combined_mass_properties_top #(
  parameter int unsigned MaxComp = cmp_pkg::MAX_COMPONENTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_group_i,
  input  wire logic [31:0] mass_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [47:0] local_ixx_i,
  input  wire logic [47:0] local_iyy_i,
  input  wire logic [47:0] local_izz_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [35:0]      total_mass_o,
  output logic signed [31:0] center_x_o,
  output logic signed [31:0] center_y_o,
  output logic signed [31:0] center_z_o,
  output logic signed [63:0] moment_xx_o,
  output logic signed [63:0] moment_yy_o,
  output logic signed [63:0] moment_zz_o,
  output logic signed [63:0] product_xy_o,
  output logic signed [63:0] product_xz_o,
  output logic signed [63:0] product_yz_o,
  output logic             fault_o
);

  localparam int unsigned AddrW  = (MaxComp > 1) ? $clog2(MaxComp) : 1;
  localparam int unsigned CntW   = $clog2(MaxComp + 1);
  localparam int unsigned SumW   = (32 + $clog2(MaxComp) > 36) ? 32 + $clog2(MaxComp) : 36;
  localparam int unsigned FirstW = 65 + $clog2(MaxComp);
  localparam int unsigned AccW   = cmp_pkg::ACC_W;
  localparam int unsigned ProdW  = cmp_pkg::PROD_W;

  cmp_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [1:0]      ax_q, ax_d;
  logic [2:0]      pk_q, pk_d;
  logic [1:0]      sub_q, sub_d;
  logic            out_valid_q, out_valid_d;

  logic                     fault_q;
  logic [SumW-1:0]          total_q;
  logic signed [FirstW-1:0] first_q [3];
  logic signed [31:0]       cen_q [3];
  logic [32:0]              u_q [3];
  logic                     dneg_q [3];
  logic [63:0]              v_q;
  logic [AccW-1:0]          acc_q [6];

  logic                     in_accept;
  logic [CntW-1:0]          cnt_eff;
  logic                     full;
  logic                     more;
  logic [CntW-1:0]          idx_next;
  logic                     adv;
  logic                     out_load;

  logic [cmp_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [31:0]              m_r;
  logic [31:0]              p_r [3];
  logic [47:0]              l_r [3];

  logic [32:0]              mul_a, mul_b;
  logic [ProdW-1:0]         prod;
  logic [32:0]              p_mag;
  logic                     p_neg;
  logic signed [FirstW-1:0] p1_ext, p1_term;

  logic [1:0]               pa, pb;
  logic [AccW-1:0]          pp, p2_term;
  logic                     p2_neg;

  logic                     div_start, div_done;
  logic [FirstW-1:0]        div_num;
  logic [cmp_pkg::QUO_W-1:0] quo;
  logic                     f_neg;
  logic [31:0]              cen_val;
  logic [cmp_pkg::QUO_W-1:0] quo_neg;

  logic                     tsat;
  logic [64:0]              sat [6];

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != cmp_pkg::S_IDLE);
  assign cnt_eff    = start_group_i ? '0 : count_q;
  assign full       = cnt_eff >= CntW'(MaxComp);
  assign idx_next   = idx_q + 1'b1;
  assign more       = idx_next < n_q;
  assign out_load   = (state_q == cmp_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // component store
  assign wdata = {local_izz_i, local_iyy_i, local_ixx_i, pos_z_i, pos_y_i, pos_x_i, mass_i};

  cmp_ram #(
    .Width (cmp_pkg::ENTRY_W),
    .Depth (MaxComp)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_accept && !full),
    .waddr_i (cnt_eff[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign m_r = rdata[31:0];
  for (genvar a = 0; a < 3; a++) begin : g_fields
    assign p_r[a] = rdata[32 + 32*a +: 32];
    assign l_r[a] = rdata[128 + 48*a +: 48];
  end

  // shared multiplier operand select
  assign p_neg = p_r[ax_q][31];
  assign p_mag = p_neg ? (33'd0 - {1'b1, p_r[ax_q]}) : {1'b0, p_r[ax_q]};
  assign pa    = cmp_pkg::pair_a(pk_q);
  assign pb    = cmp_pkg::pair_b(pk_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      cmp_pkg::S_P1_MUL: begin
        mul_a = p_mag;
        mul_b = {1'b0, m_r};
      end
      cmp_pkg::S_P2_MUL, cmp_pkg::S_P2_ACC: begin
        case (sub_q)
          cmp_pkg::SUB_SQ: begin
            mul_a = u_q[pa];
            mul_b = u_q[pb];
          end
          cmp_pkg::SUB_LO: begin
            mul_a = {1'b0, v_q[31:0]};
            mul_b = {1'b0, m_r};
          end
          default: begin
            mul_a = {1'b0, v_q[63:32]};
            mul_b = {1'b0, m_r};
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cmp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign p1_ext  = {{(FirstW-ProdW){1'b0}}, prod};
  assign p1_term = p_neg ? -p1_ext : p1_ext;

  assign pp      = (sub_q == cmp_pkg::SUB_HI) ? {30'd0, prod, 32'd0} : {62'd0, prod};
  assign p2_neg  = (pk_q >= cmp_pkg::PAIR_FIRST_PROD) && (dneg_q[pa] == dneg_q[pb]);
  assign p2_term = p2_neg ? (AccW'(0) - pp) : pp;

  // centre division
  assign f_neg     = first_q[ax_q][FirstW-1];
  assign div_num   = f_neg ? (FirstW'(0) - first_q[ax_q]) : first_q[ax_q];
  assign div_start = (state_q == cmp_pkg::S_DIV_START);

  cmp_div #(
    .NumW (FirstW),
    .DenW (SumW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (total_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign quo_neg = cmp_pkg::QUO_W'(0) - quo;
  always_comb begin
    if (f_neg) begin
      cen_val = quo_neg[31:0];
    end else if (quo[32] || quo[31]) begin
      cen_val = 32'h7FFF_FFFF;
    end else begin
      cen_val = quo[31:0];
    end
  end

  // sequencer
  assign adv = ((state_q == cmp_pkg::S_P2_ACC) && (sub_q != cmp_pkg::SUB_SQ) &&
                (pk_q >= cmp_pkg::PAIR_FIRST_PROD)) || (state_q == cmp_pkg::S_P2_ACC2);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    idx_d       = idx_q;
    ax_d        = ax_q;
    pk_d        = pk_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      cmp_pkg::S_IDLE: begin
        if (in_accept) begin
          count_d = full ? cnt_eff : cnt_eff + 1'b1;
          n_d     = count_d;
          idx_d   = '0;
          ax_d    = '0;
          state_d = cmp_pkg::S_P1_LOAD;
        end
      end
      cmp_pkg::S_P1_LOAD: state_d = cmp_pkg::S_P1_MUL;
      cmp_pkg::S_P1_MUL:  state_d = cmp_pkg::S_P1_ACC;
      cmp_pkg::S_P1_ACC: begin
        if (ax_q != cmp_pkg::AXIS_LAST) begin
          ax_d    = ax_q + 1'b1;
          state_d = cmp_pkg::S_P1_MUL;
        end else begin
          ax_d = '0;
          if (more) begin
            idx_d   = idx_next;
            state_d = cmp_pkg::S_P1_LOAD;
          end else if (total_q == '0) begin
            idx_d   = '0;
            state_d = cmp_pkg::S_P2_LOAD;
          end else begin
            state_d = cmp_pkg::S_DIV_START;
          end
        end
      end
      cmp_pkg::S_DIV_START: state_d = cmp_pkg::S_DIV_WAIT;
      cmp_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (ax_q == cmp_pkg::AXIS_LAST) begin
            ax_d    = '0;
            idx_d   = '0;
            state_d = cmp_pkg::S_P2_LOAD;
          end else begin
            ax_d    = ax_q + 1'b1;
            state_d = cmp_pkg::S_DIV_START;
          end
        end
      end
      cmp_pkg::S_P2_LOAD: state_d = cmp_pkg::S_P2_LATCH;
      cmp_pkg::S_P2_LATCH: begin
        pk_d    = '0;
        sub_d   = cmp_pkg::SUB_SQ;
        state_d = cmp_pkg::S_P2_MUL;
      end
      cmp_pkg::S_P2_MUL: state_d = cmp_pkg::S_P2_ACC;
      cmp_pkg::S_P2_ACC: begin
        if (sub_q == cmp_pkg::SUB_SQ) begin
          sub_d   = cmp_pkg::SUB_LO;
          state_d = cmp_pkg::S_P2_MUL;
        end else if (pk_q < cmp_pkg::PAIR_FIRST_PROD) begin
          state_d = cmp_pkg::S_P2_ACC2;
        end
      end
      cmp_pkg::S_P2_ACC2: state_d = cmp_pkg::S_P2_MUL;
      cmp_pkg::S_P2_LOC: begin
        if (ax_q == cmp_pkg::AXIS_LAST) begin
          ax_d = '0;
          if (more) begin
            idx_d   = idx_next;
            state_d = cmp_pkg::S_P2_LOAD;
          end else begin
            state_d = cmp_pkg::S_DONE;
          end
        end else begin
          ax_d = ax_q + 1'b1;
        end
      end
      cmp_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = cmp_pkg::S_IDLE;
        end
      end
      default: state_d = cmp_pkg::S_IDLE;
    endcase

    if (adv) begin
      if (sub_q == cmp_pkg::SUB_LO) begin
        sub_d   = cmp_pkg::SUB_HI;
        state_d = cmp_pkg::S_P2_MUL;
      end else begin
        sub_d = cmp_pkg::SUB_SQ;
        if (pk_q == cmp_pkg::PAIR_LAST) begin
          ax_d    = '0;
          state_d = cmp_pkg::S_P2_LOC;
        end else begin
          pk_d    = pk_q + 1'b1;
          state_d = cmp_pkg::S_P2_MUL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmp_pkg::S_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      ax_q        <= '0;
      pk_q        <= '0;
      sub_q       <= cmp_pkg::SUB_SQ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      ax_q        <= ax_d;
      pk_q        <= pk_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  logic [32:0] d_w [3];
  for (genvar a = 0; a < 3; a++) begin : g_off
    assign d_w[a] = {p_r[a][31], p_r[a]} - {cen_q[a][31], cen_q[a]};
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fault_q <= full;
      total_q <= '0;
      for (int a = 0; a < 3; a++) begin
        first_q[a] <= '0;
        cen_q[a]   <= '0;
      end
      for (int t = 0; t < 6; t++) begin
        acc_q[t] <= '0;
      end
    end
    case (state_q)
      cmp_pkg::S_P1_ACC: begin
        first_q[ax_q] <= first_q[ax_q] + p1_term;
        if (ax_q == 2'd0) begin
          total_q <= total_q + SumW'(m_r);
        end
        if ((ax_q == cmp_pkg::AXIS_LAST) && !more && (total_q == '0)) begin
          fault_q <= 1'b1;
        end
      end
      cmp_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          cen_q[ax_q] <= cen_val;
        end
      end
      cmp_pkg::S_P2_LATCH: begin
        for (int a = 0; a < 3; a++) begin
          dneg_q[a] <= d_w[a][32];
          u_q[a]    <= d_w[a][32] ? (33'd0 - d_w[a]) : d_w[a];
        end
      end
      cmp_pkg::S_P2_ACC: begin
        if (sub_q == cmp_pkg::SUB_SQ) begin
          v_q <= prod[63:0];
        end else begin
          acc_q[cmp_pkg::pair_tgt1(pk_q)] <= acc_q[cmp_pkg::pair_tgt1(pk_q)] + p2_term;
        end
      end
      cmp_pkg::S_P2_ACC2: begin
        acc_q[cmp_pkg::pair_tgt2(pk_q)] <= acc_q[cmp_pkg::pair_tgt2(pk_q)] + p2_term;
      end
      cmp_pkg::S_P2_LOC: begin
        acc_q[{1'b0, ax_q}] <= acc_q[{1'b0, ax_q}] + {48'd0, l_r[ax_q], 32'd0};
      end
      default: begin
      end
    endcase
  end

  // result word
  assign tsat = total_q > SumW'(cmp_pkg::TOTAL_MAX);
  for (genvar t = 0; t < 6; t++) begin : g_sat
    assign sat[t] = cmp_pkg::q16_sat(acc_q[t]);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      total_mass_o <= tsat ? cmp_pkg::TOTAL_MAX : total_q[35:0];
      center_x_o   <= cen_q[0];
      center_y_o   <= cen_q[1];
      center_z_o   <= cen_q[2];
      moment_xx_o  <= sat[0][63:0];
      moment_yy_o  <= sat[1][63:0];
      moment_zz_o  <= sat[2][63:0];
      product_xy_o <= sat[3][63:0];
      product_xz_o <= sat[4][63:0];
      product_yz_o <= sat[5][63:0];
      fault_o      <= fault_q | tsat | sat[0][64] | sat[1][64] | sat[2][64] |
                      sat[3][64] | sat[4][64] | sat[5][64];
    end
  end

  assign out_valid_o = out_valid_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxComp))
    else $error("component count beyond store depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cmp_pkg::S_P1_LOAD || state_q == cmp_pkg::S_P2_LOAD) |-> idx_q < n_q)
    else $error("store index beyond component count");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && state_q == cmp_pkg::S_IDLE)
    else $error("finished word not presented");

  a_zero_mass_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && total_mass_o == 36'd0) |-> fault_o)
    else $error("zero total mass without fault");

endmodule

`default_nettype wire

[rtl/core/cmp_ram.sv]
`default_nettype none

module cmp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/cmp_mul.sv]
`default_nettype none

module cmp_mul (
  input  wire logic                        clk_i,
  input  wire logic [cmp_pkg::OPND_W-1:0]  a_i,
  input  wire logic [cmp_pkg::OPND_W-1:0]  b_i,
  output logic      [cmp_pkg::PROD_W-1:0]  prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule

`default_nettype wire

[rtl/core/cmp_div.sv]
`default_nettype none

module cmp_div #(
  parameter int unsigned NumW = 69,
  parameter int unsigned DenW = 36
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [NumW-1:0]            num_i,
  input  wire logic [DenW-1:0]            den_i,
  output logic                            done_o,
  output logic [cmp_pkg::QUO_W-1:0]       quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic                      busy_q;
  logic                      done_q;
  logic [CntW-1:0]           cnt_q;
  logic [NumW-1:0]           num_q;
  logic [DenW-1:0]           den_q;
  logic [DenW-1:0]           rem_q;
  logic [cmp_pkg::QUO_W-1:0] q_q;
  logic                      ovf_q;

  logic [DenW:0]   rem_sh;
  logic [DenW:0]   diff;
  logic            ge;
  logic            over;

  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
      q_q   <= {q_q[cmp_pkg::QUO_W-2:0], ge};
      ovf_q <= ovf_q | q_q[cmp_pkg::QUO_W-1];
    end
  end

  assign over   = ovf_q | q_q[32] | (q_q[31] & (|q_q[30:0]));
  assign quo_o  = over ? cmp_pkg::QUO_CLAMP : q_q;
  assign done_o = done_q;

endmodule

`default_nettype wire
